FILE: rtl/dmm_pkg.sv
package dmm_pkg;

  // sizes of the text store and the display line
  localparam int MAX_CHARS       = 64;
  localparam int MAX_SCREEN_COLS = 256;

  // character cell geometry
  localparam int GLYPH_W  = 5;
  localparam int CELL_W   = 6;
  localparam int WRAP_GAP = 12;
  localparam int FONT_N   = 96;

  // register and field widths
  localparam int LEN_W   = 7;
  localparam int SCR_W   = 9;
  localparam int DATA_W  = 9;
  localparam int POS_W   = 6;
  localparam int CODE_W  = 8;
  localparam int COLIN_W = 8;
  localparam int DOTS_W  = 7;
  localparam int STORE_W = 7;
  localparam int IDX_W   = $clog2(MAX_CHARS);
  localparam int CHARS_W = $clog2(MAX_CHARS + 1);
  localparam int MAXSPAN = MAX_CHARS * CELL_W + WRAP_GAP;
  localparam int COL_W   = $clog2(((MAXSPAN > MAX_SCREEN_COLS) ? MAXSPAN : MAX_SCREEN_COLS) + 1);
  localparam int SUM_W   = COL_W + 1;
  localparam int REM_W   = $clog2(CELL_W);
  localparam int FONT_AW = $clog2(FONT_N);

  // divide by six: src * 171 >> 10 is exact for src below 400
  localparam int DIV6_MUL   = 171;
  localparam int DIV6_SHIFT = 10;
  localparam int DIV6_MW    = 8;

  // printable range of the character set
  localparam logic [CODE_W-1:0]  CODE_FIRST = 8'h20;
  localparam logic [CODE_W-1:0]  CODE_LAST  = 8'h7E;
  localparam logic [STORE_W-1:0] CODE_SPACE = 7'h20;

  // request codes
  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_TICK  = 2'd1,
    REQ_READ  = 2'd2
  } dmm_req_t;

  // register indexes
  localparam logic [1:0] REG_TEXT_LENGTH    = 2'd0;
  localparam logic [1:0] REG_SCREEN_COLUMNS = 2'd1;
  localparam logic [1:0] REG_SCROLL_ENABLE  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_NORM,
    S_WRITE,
    S_TICK,
    S_BLANK,
    S_LOCATE,
    S_SPLIT,
    S_GLYPH
  } dmm_state_t;

  typedef struct packed {
    logic load;
    logic cfg_wr;
    logic norm;
    logic wr;
    logic tick;
    logic locate;
    logic split;
    logic emit_blank;
    logic emit_glyph;
  } dmm_cmd_t;

  typedef struct packed {
    logic norm_pending;
  } dmm_stat_t;

  // 5x7 font, first column in the top byte, bit 0 is the top row
  localparam logic [39:0] FONT_ROM [FONT_N] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
    40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
    40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
    40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
    40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
    40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
    40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
    40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
    40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
    40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
    40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
    40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
    40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
    40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040,
    40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
    40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h0C5252523E,
    40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h7F10284400,
    40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
    40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
    40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
    40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
    40'h00007F0000, 40'h0041360800, 40'h0804081008, 40'h0000000000
  };

  function automatic logic [DOTS_W-1:0] font_column(input logic [STORE_W-1:0] code,
                                                    input logic [REM_W-1:0]   col);
    logic [FONT_AW-1:0] glyph;
    logic [39:0]        bits;
    logic [7:0]         col_byte;
    glyph = FONT_AW'(code - CODE_SPACE);
    bits  = FONT_ROM[glyph];
    case (col)
      3'd0:    col_byte = bits[39:32];
      3'd1:    col_byte = bits[31:24];
      3'd2:    col_byte = bits[23:16];
      3'd3:    col_byte = bits[15:8];
      3'd4:    col_byte = bits[7:0];
      default: col_byte = 8'h00;
    endcase
    if (code < CODE_SPACE) begin
      col_byte = 8'h00;
    end
    return col_byte[DOTS_W-1:0];
  endfunction

endpackage

FILE: rtl/dmm_ram.sv
module dmm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: rtl/dmm_ctrl.sv
module dmm_ctrl
  import dmm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic [1:0] req_type,
  input  logic      cfg_valid,
  input  dmm_stat_t stat,
  output dmm_cmd_t  cmd,
  output logic      busy,
  output logic      cfg_ready
);

  dmm_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = (state != S_IDLE);
    cfg_ready  = (state == S_IDLE) && !start;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          case (req_type)
            REQ_WRITE: state_next = S_WRITE;
            REQ_TICK:  state_next = S_TICK;
            REQ_READ:  state_next = S_LOCATE;
            default:   state_next = S_BLANK;
          endcase
        end else if (cfg_valid) begin
          cmd.cfg_wr = 1'b1;
          state_next = S_NORM;
        end
      end
      S_NORM: begin
        // bring the scroll position back under the new period
        if (stat.norm_pending) begin
          cmd.norm = 1'b1;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_WRITE: begin
        cmd.wr         = 1'b1;
        cmd.emit_blank = 1'b1;
        state_next     = S_IDLE;
      end
      S_TICK: begin
        cmd.tick       = 1'b1;
        cmd.emit_blank = 1'b1;
        state_next     = S_IDLE;
      end
      S_BLANK: begin
        cmd.emit_blank = 1'b1;
        state_next     = S_IDLE;
      end
      S_LOCATE: begin
        cmd.locate = 1'b1;
        state_next = S_SPLIT;
      end
      S_SPLIT: begin
        cmd.split  = 1'b1;
        state_next = S_GLYPH;
      end
      S_GLYPH: begin
        cmd.emit_glyph = 1'b1;
        state_next     = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_accept_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not make the block busy");

  a_cfg_not_during_item: assert property (@(posedge clk) disable iff (rst)
    (cmd.cfg_wr) |-> (!start && state == S_IDLE))
    else $error("register write taken while a request is in flight");
`endif

endmodule

FILE: rtl/dmm_datapath.sv
module dmm_datapath
  import dmm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  dmm_cmd_t           cmd,
  output dmm_stat_t          stat,
  input  logic [POS_W-1:0]   char_pos,
  input  logic [CODE_W-1:0]  char_code,
  input  logic [COLIN_W-1:0] column,
  input  logic [1:0]         cfg_index,
  input  logic [DATA_W-1:0]  cfg_data,
  output logic               done,
  output logic [DOTS_W-1:0]  dots,
  output logic               overflowing
);

  // configuration registers
  logic [LEN_W-1:0] text_length;
  logic [SCR_W-1:0] screen_columns;
  logic             scroll_enable;

  // scroll state: position as last set, and its remainder under the current period
  logic [COL_W-1:0] scroll_raw;
  logic [COL_W-1:0] scroll;

  // latched request
  logic [POS_W-1:0]   pos_q;
  logic [CODE_W-1:0]  code_q;
  logic [COLIN_W-1:0] col_q;

  // column pipeline
  logic [COL_W-1:0] src_q;
  logic             hit_q;
  logic [REM_W-1:0] rem_q;
  logic             rhit_q;

  // derived geometry
  logic [CHARS_W-1:0] shown;
  logic [COL_W-1:0]   visible;
  logic [COL_W-1:0]   text_cols;
  logic [COL_W-1:0]   period;
  logic               ovf;
  logic [COL_W-1:0]   center_start;
  logic [COL_W-1:0]   col_ext;
  logic [SUM_W-1:0]   sum;
  logic [SUM_W-1:0]   sum_wrap;
  logic [COL_W-1:0]   src_next;
  logic               hit_next;
  logic [COL_W+DIV6_MW-1:0] prod;
  logic [IDX_W-1:0]   idx;
  logic [COL_W-1:0]   idx_x6;
  logic [COL_W-1:0]   rem_full;
  logic [COL_W-1:0]   scroll_inc;

  // text store port
  logic               ram_we;
  logic [IDX_W-1:0]   ram_addr;
  logic [STORE_W-1:0] ram_wdata;
  logic [STORE_W-1:0] ram_rdata;

  always_comb begin
    shown = (text_length > LEN_W'(MAX_CHARS)) ? CHARS_W'(MAX_CHARS) : CHARS_W'(text_length);
    visible = (screen_columns > SCR_W'(MAX_SCREEN_COLS)) ? COL_W'(MAX_SCREEN_COLS)
                                                         : COL_W'(screen_columns);
    text_cols    = (COL_W'(shown) << 2) + (COL_W'(shown) << 1);
    period       = text_cols + COL_W'(WRAP_GAP);
    ovf          = text_cols > visible;
    center_start = (visible - text_cols) >> 1;
    col_ext      = COL_W'(col_q);
    stat.norm_pending = scroll >= period;
  end

  // screen column to text column
  always_comb begin
    sum      = SUM_W'(col_ext) + SUM_W'(scroll);
    sum_wrap = (sum >= SUM_W'(period)) ? (sum - SUM_W'(period)) : sum;
    if (ovf) begin
      src_next = sum_wrap[COL_W-1:0];
      hit_next = col_ext < visible;
    end else begin
      src_next = col_ext - center_start;
      hit_next = (col_ext < visible) && (col_ext >= center_start);
    end
  end

  // text column to character index and glyph column
  always_comb begin
    prod     = (COL_W+DIV6_MW)'(src_q) * (COL_W+DIV6_MW)'(DIV6_MUL);
    idx      = prod[DIV6_SHIFT +: IDX_W];
    idx_x6   = (COL_W'(idx) << 2) + (COL_W'(idx) << 1);
    rem_full = src_q - idx_x6;
  end

  always_comb begin
    scroll_inc = scroll + COL_W'(1);
    ram_we     = cmd.wr;
    ram_addr   = cmd.wr ? IDX_W'(pos_q) : idx;
    ram_wdata  = ((code_q >= CODE_FIRST) && (code_q <= CODE_LAST)) ? code_q[STORE_W-1:0]
                                                                   : CODE_SPACE;
  end

  dmm_ram #(
    .WIDTH (STORE_W),
    .DEPTH (MAX_CHARS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      text_length    <= '0;
      screen_columns <= SCR_W'(64);
      scroll_enable  <= 1'b1;
    end else if (cmd.cfg_wr) begin
      case (cfg_index)
        REG_TEXT_LENGTH:    text_length    <= cfg_data[LEN_W-1:0];
        REG_SCREEN_COLUMNS: screen_columns <= cfg_data[SCR_W-1:0];
        REG_SCROLL_ENABLE:  scroll_enable  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scroll     <= '0;
      scroll_raw <= '0;
    end else if (cmd.wr) begin
      scroll     <= '0;
      scroll_raw <= '0;
    end else if (cmd.cfg_wr) begin
      // restart the reduction from the position as last set
      scroll <= scroll_raw;
    end else if (cmd.norm) begin
      scroll <= scroll - period;
    end else if (cmd.tick) begin
      if (!ovf) begin
        scroll     <= '0;
        scroll_raw <= '0;
      end else if (scroll_enable) begin
        scroll     <= (scroll_inc == period) ? '0 : scroll_inc;
        scroll_raw <= (scroll_inc == period) ? '0 : scroll_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pos_q  <= char_pos;
      code_q <= char_code;
      col_q  <= column;
    end
    if (cmd.locate) begin
      src_q <= src_next;
      hit_q <= hit_next;
    end
    if (cmd.split) begin
      rem_q  <= rem_full[REM_W-1:0];
      rhit_q <= hit_q && (src_q < text_cols);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit_blank || cmd.emit_glyph;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_blank || cmd.emit_glyph) begin
      dots        <= (cmd.emit_glyph && rhit_q) ? font_column(ram_rdata, rem_q) : '0;
      overflowing <= ovf;
    end
  end

`ifndef SYNTHESIS
  a_scroll_in_period: assert property (@(posedge clk) disable iff (rst)
    cmd.locate |-> (scroll < period))
    else $error("scroll position not reduced before a column read");

  a_write_clears_scroll: assert property (@(posedge clk) disable iff (rst)
    cmd.wr |=> (scroll == '0))
    else $error("character write left the scroll position");

  a_lit_only_from_glyph: assert property (@(posedge clk) disable iff (rst)
    (done && dots != '0) |-> $past(cmd.emit_glyph))
    else $error("lit dots on a result that is not a column read");
`endif

endmodule

FILE: rtl/dot_matrix_marquee_column_generator.sv
// character generator for one 7-row dot-matrix line. a request is taken at a
// clock edge with start high and busy low; its single result appears on dots
// and overflowing for exactly one cycle while done is high, and the receiver
// cannot hold it off. req_type selects a character write (stored at char_pos,
// codes outside 0x20..0x7e kept as space, scroll position cleared), a scroll
// tick, or a read of one screen column; any other type just returns a blank
// result. for character writes, ticks and unused types the request edge
// enters a state that emits the result; a column read runs locate, index
// split and text store plus font lookup in turn. busy stays high until the
// block is back in idle, so no new request is taken before the last one
// has emitted its result. the text store is a single-port memory shared by
// writes and reads, which sets the read sequence. register writes go
// through cfg_valid/cfg_ready while no request is pending; after each one
// the scroll position as last set is brought under the new wrap period by
// repeated subtraction, 0 to 32 steps, while busy stays high and cfg_ready
// low. text that fits on screen_columns is centered; longer text scrolls
// with a wrap period of six columns per character plus twelve blank ones
module dot_matrix_marquee_column_generator
  import dmm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // request channel
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         req_type,
  input  logic [POS_W-1:0]   char_pos,
  input  logic [CODE_W-1:0]  char_code,
  input  logic [COLIN_W-1:0] column,
  // result channel
  output logic               done,
  output logic [DOTS_W-1:0]  dots,
  output logic               overflowing,
  // register write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [DATA_W-1:0]  cfg_data
);

  // command and status between sequencer and datapath
  dmm_cmd_t  cmd;
  dmm_stat_t stat;

  dmm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .req_type  (req_type),
    .cfg_valid (cfg_valid),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .cfg_ready (cfg_ready)
  );

  // configuration, scroll state, text store, font lookup and result registers
  dmm_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .char_pos    (char_pos),
    .char_code   (char_code),
    .column      (column),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .done        (done),
    .dots        (dots),
    .overflowing (overflowing)
  );

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps

// this file's only module is tb_top
module tb_top;
  import dmm_pkg::*;

  // request code that the block answers with a blank result
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // geometry and character set as the display sees them
  localparam int          STORE_CHARS = 64;
  localparam int          SCREEN_MAX  = 256;
  localparam int          CELL_COLS   = 6;
  localparam int          GLYPH_COLS  = 5;
  localparam int          GAP_COLS    = 12;
  localparam logic [7:0]  FIRST_PRINT = 8'h20;
  localparam logic [7:0]  LAST_PRINT  = 8'h7E;
  localparam logic [6:0]  SPACE_CODE  = 7'h20;

  // 5x7 glyphs for codes 0x20..0x7f, leftmost column in the top byte
  localparam logic [39:0] GLYPHS [96] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
    40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
    40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
    40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
    40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
    40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
    40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
    40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
    40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
    40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
    40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
    40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
    40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
    40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040,
    40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
    40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h0C5252523E,
    40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h7F10284400,
    40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
    40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
    40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
    40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
    40'h00007F0000, 40'h0041360800, 40'h0804081008, 40'h0000000000
  };

  // one request as the driver presents it
  typedef struct packed {
    logic [1:0]         req;
    logic [POS_W-1:0]   pos;
    logic [CODE_W-1:0]  code;
    logic [COLIN_W-1:0] col;
  } marquee_req_t;

  // one column result as the block should return it
  typedef struct packed {
    logic [DOTS_W-1:0] dots;
    logic              ovf;
  } column_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         req_type = '0;
  logic [POS_W-1:0]   char_pos = '0;
  logic [CODE_W-1:0]  char_code = '0;
  logic [COLIN_W-1:0] column = '0;
  logic               done;
  logic [DOTS_W-1:0]  dots;
  logic               overflowing;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [DATA_W-1:0]  cfg_data = '0;

  // requests waiting for the driver, and column results still owed by the block
  marquee_req_t   pending_reqs[$];
  column_result_t expected_columns[$];

  // shadow copy of the display state
  logic [6:0]  shadow_text [STORE_CHARS];
  int unsigned shadow_scroll;
  int unsigned shadow_len;
  int unsigned shadow_screen;
  bit          shadow_scroll_en;

  // stimulus bookkeeping: text positions that hold a character
  bit filled [STORE_CHARS];
  bit calm;
  int work_items;
  int errors;
  int n_reads, n_ticks, n_writes, n_unused, n_settings;

  always #6 clk = ~clk;

  dot_matrix_marquee_column_generator u_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req_type    (req_type),
    .char_pos    (char_pos),
    .char_code   (char_code),
    .column      (column),
    .done        (done),
    .dots        (dots),
    .overflowing (overflowing),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // display model
  // ---------------------------------------------------------------------------

  // length and screen registers saturate at the store and screen sizes
  function automatic int unsigned shown_chars();
    return (shadow_len > STORE_CHARS) ? STORE_CHARS : shadow_len;
  endfunction

  function automatic int unsigned visible_cols();
    return (shadow_screen > SCREEN_MAX) ? SCREEN_MAX : shadow_screen;
  endfunction

  function automatic bit text_overflows();
    return shown_chars() * CELL_COLS > visible_cols();
  endfunction

  // dots of one screen column: centered when the text fits, scrolled otherwise
  function automatic logic [DOTS_W-1:0] column_dots(input int unsigned c);
    int unsigned scr, text_cols, period, left, src, cell_col;
    logic [6:0]  code7;
    logic [39:0] shifted;
    scr       = visible_cols();
    text_cols = shown_chars() * CELL_COLS;
    if (c >= scr) return '0;
    if (text_cols > scr) begin
      // a stale position from an older setting is folded into the current period
      period = text_cols + GAP_COLS;
      src    = (c + shadow_scroll % period) % period;
    end else begin
      left = (scr - text_cols) / 2;
      if (c < left) return '0;
      src = c - left;
    end
    // the wrap gap and the blank sixth column of each cell are dark
    if (src >= text_cols) return '0;
    cell_col = src % CELL_COLS;
    if (cell_col >= GLYPH_COLS) return '0;
    code7 = shadow_text[src / CELL_COLS];
    if (code7 < SPACE_CODE) return '0;
    shifted = GLYPHS[code7 - SPACE_CODE] >> (8 * (GLYPH_COLS - 1 - cell_col));
    return shifted[6:0];
  endfunction

  // applies one accepted request to the shadow state and returns its result
  function automatic column_result_t marquee_step(input marquee_req_t r);
    column_result_t res;
    int unsigned    period;
    res.dots = '0;
    case (r.req)
      REQ_WRITE: begin
        // unprintable codes are kept as space; any write restarts the scroll
        shadow_text[r.pos] = (r.code < FIRST_PRINT || r.code > LAST_PRINT) ?
                             SPACE_CODE : r.code[6:0];
        shadow_scroll = 0;
      end
      REQ_TICK: begin
        if (!text_overflows()) begin
          shadow_scroll = 0;
        end else if (shadow_scroll_en) begin
          period        = shown_chars() * CELL_COLS + GAP_COLS;
          shadow_scroll = (shadow_scroll % period + 1) % period;
        end
      end
      REQ_READ: begin
        res.dots = column_dots(r.col);
      end
      default: begin
      end
    endcase
    // overflow flag reflects the state after the request
    res.ovf = text_overflows();
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // driver: presents queued requests, idling at random between them unless calm is set
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    marquee_req_t taken;
    marquee_req_t next_req;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        // request accepted at this edge: predict its column result now
        taken.req  = req_type;
        taken.pos  = char_pos;
        taken.code = char_code;
        taken.col  = column;
        expected_columns.push_back(marquee_step(taken));
        case (taken.req)
          REQ_WRITE: n_writes++;
          REQ_TICK:  n_ticks++;
          REQ_READ:  n_reads++;
          default:   n_unused++;
        endcase
      end
      // a request not yet taken stays on the ports unchanged
      if (!start || !busy) begin
        if (pending_reqs.size() != 0 && (calm || $urandom_range(0, 99) >= 28)) begin
          next_req  = pending_reqs.pop_front();
          start     <= 1'b1;
          req_type  <= next_req.req;
          char_pos  <= next_req.pos;
          char_code <= next_req.code;
          column    <= next_req.col;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: every done strobe is matched against the oldest expected column
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    column_result_t want;
    if (!rst && done === 1'b1) begin
      if (expected_columns.size() == 0) begin
        $error("unexpected result: dots=%02h overflowing=%0b", dots, overflowing);
        errors++;
      end else begin
        want = expected_columns.pop_front();
        if (dots !== want.dots) begin
          $error("dots: expected %02h, actual %02h", want.dots, dots);
          errors++;
        end
        if (overflowing !== want.ovf) begin
          $error("overflowing: expected %0b, actual %0b", want.ovf, overflowing);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_req(input logic [1:0] rq, input logic [POS_W-1:0] pos,
                           input logic [CODE_W-1:0] code, input logic [COLIN_W-1:0] col);
    marquee_req_t r;
    r.req  = rq;
    r.pos  = pos;
    r.code = code;
    r.col  = col;
    pending_reqs.push_back(r);
    if (rq == REQ_WRITE) filled[pos] = 1'b1;
    if (rq != REQ_UNUSED) work_items++;
  endtask

  // sender holds off until every queued request has been taken and answered
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || start || expected_columns.size() != 0);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk);
    while (cfg_ready !== 1'b1);
    case (idx)
      REG_TEXT_LENGTH:    shadow_len       = data[6:0];
      REG_SCREEN_COLUMNS: shadow_screen    = data[8:0];
      REG_SCROLL_ENABLE:  shadow_scroll_en = data[0];
      default: begin
      end
    endcase
    cfg_valid <= 1'b0;
  endtask

  // new register setting; every shown position gets a character first so
  // that no lit column is taken from an unwritten store entry
  task automatic set_config(input logic [DATA_W-1:0] len_d, input logic [DATA_W-1:0] scr_d,
                            input logic [DATA_W-1:0] en_d);
    int unsigned need;
    need = (len_d[6:0] > STORE_CHARS) ? STORE_CHARS : len_d[6:0];
    for (int p = 0; p < need; p++) begin
      if (!filled[p]) queue_req(REQ_WRITE, POS_W'(p), 8'($urandom_range(32, 126)), '0);
    end
    wait_drained();
    write_reg(REG_TEXT_LENGTH, len_d);
    write_reg(REG_SCREEN_COLUMNS, scr_d);
    write_reg(REG_SCROLL_ENABLE, en_d);
    n_settings++;
  endtask

  // random requests; a scrolling burst has almost no writes so that the
  // scroll position gets to travel and wrap
  task automatic random_reqs(input int n, input bit scrolling);
    int unsigned      roll, scr;
    logic [1:0]       rq;
    logic [CODE_W-1:0] cd;
    logic [COLIN_W-1:0] cl;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < (scrolling ? 1 : 12))       rq = REQ_WRITE;
      else if (roll < (scrolling ? 45 : 35)) rq = REQ_TICK;
      else if (roll < 97)                    rq = REQ_READ;
      else                                   rq = REQ_UNUSED;
      cd  = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(32, 126)) : 8'($urandom);
      scr = visible_cols();
      // mostly columns on screen, the rest anywhere
      cl  = (scr > 0 && $urandom_range(0, 4) != 0) ? 8'($urandom_range(0, scr - 1))
                                                    : 8'($urandom);
      queue_req(rq, POS_W'($urandom), cd, cl);
    end
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [DATA_W-1:0] len_d, scr_d, en_d;
    int phase;
    shadow_scroll    = 0;
    shadow_len       = 0;
    shadow_screen    = 64;
    shadow_scroll_en = 1'b1;
    for (int p = 0; p < STORE_CHARS; p++) begin
      shadow_text[p] = '0;
      filled[p]      = 1'b0;
    end
    calm = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset values written back explicitly; empty text shows nothing
    set_config(9'd0, 9'd64, 9'd1);
    queue_req(REQ_WRITE, 6'd0, 8'h41, '0);
    queue_req(REQ_WRITE, 6'd1, 8'h7E, '0);
    queue_req(REQ_WRITE, 6'd2, 8'h00, '0);        // control code becomes space
    queue_req(REQ_WRITE, 6'd3, 8'hFF, '0);        // top code becomes space
    queue_req(REQ_WRITE, 6'd63, 8'h7F, '0);       // delete becomes space
    queue_req(REQ_WRITE, 6'd62, 8'h20, '0);
    queue_req(REQ_READ, 6'd0, 8'h00, 8'd0);
    queue_req(REQ_READ, 6'd63, 8'hFF, 8'd255);    // off screen
    queue_req(REQ_TICK, 6'd0, 8'h00, 8'd0);       // no overflow, position cleared
    queue_req(REQ_UNUSED, 6'd63, 8'hFF, 8'd255);

    // four characters centered on 64 columns: text spans 20..43
    set_config(9'd4, 9'd64, 9'd1);
    queue_req(REQ_READ, '0, '0, 8'd19);
    queue_req(REQ_READ, '0, '0, 8'd20);
    queue_req(REQ_READ, '0, '0, 8'd25);
    queue_req(REQ_READ, '0, '0, 8'd26);
    queue_req(REQ_READ, '0, '0, 8'd43);
    queue_req(REQ_READ, '0, '0, 8'd44);

    // zero-width screen: nonempty text overflows, every read is dark
    set_config(9'd4, 9'd0, 9'd1);
    queue_req(REQ_READ, '0, '0, 8'd0);
    queue_req(REQ_TICK, '0, '0, '0);
    queue_req(REQ_TICK, '0, '0, '0);

    // one-column screen with scrolling held: tick keeps the stale position
    set_config(9'd4, 9'd1, 9'd0);
    queue_req(REQ_TICK, '0, '0, '0);
    queue_req(REQ_READ, '0, '0, 8'd0);

    // length and screen above their bounds saturate
    set_config(9'd127, 9'd511, 9'd1);
    queue_req(REQ_READ, '0, '0, 8'd0);
    queue_req(REQ_READ, '0, '0, 8'd255);
    queue_req(REQ_TICK, '0, '0, '0);
    queue_req(REQ_READ, '0, '0, 8'd0);

    // random settings, each followed by a burst of requests; the drain in
    // set_config pauses the sender until all results are back
    phase = 0;
    while (work_items < 1950) begin
      case ($urandom_range(0, 5))
        0:       len_d = 9'($urandom_range(1, 10));
        1:       len_d = 9'($urandom_range(0, 64));
        2:       len_d = 9'd64;
        3:       len_d = 9'($urandom_range(65, 127));
        4:       len_d = 9'($urandom);
        default: len_d = 9'($urandom_range(2, 8));
      endcase
      case ($urandom_range(0, 7))
        0:       scr_d = 9'd0;
        1:       scr_d = 9'd1;
        2:       scr_d = 9'($urandom_range(1, 64));
        3:       scr_d = 9'($urandom_range(1, 256));
        4:       scr_d = 9'd256;
        5:       scr_d = 9'($urandom_range(257, 511));
        default: scr_d = 9'($urandom_range(8, 48));
      endcase
      case ($urandom_range(0, 5))
        0:       en_d = 9'd0;
        1:       en_d = 9'($urandom);
        default: en_d = 9'd1;
      endcase
      set_config(len_d, scr_d, en_d);
      // one burst runs without any sender idle cycles
      calm = (phase == 2);
      random_reqs($urandom_range(60, 180), 1'($urandom_range(0, 1)));
      phase++;
    end

    wait_drained();
    calm = 1'b0;
    // keep watching to catch a stray result strobe
    repeat (10) @(posedge clk);

    $display("covered %0d column reads, %0d ticks, %0d writes, %0d unused requests",
             n_reads, n_ticks, n_writes, n_unused);
    $display("across %0d register settings, %0d mismatches", n_settings, errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #(400_000 * 12);
    $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: files.f
rtl/dmm_pkg.sv
rtl/dmm_ram.sv
rtl/dmm_ctrl.sv
rtl/dmm_datapath.sv
rtl/dot_matrix_marquee_column_generator.sv
verif/tb_top.sv
